// ===== rtl/core/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types, codes and helpers for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int VAL_W  = 32;
    localparam int POS_W  = 7;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 7;
    localparam int WAIT_W = 3;
    localparam int FANIN  = 8;

    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_POS  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // Control broadcast from the sequencer to every cell of the row.
    typedef struct packed {
        logic             go;     // an item is accepted this cycle
        logic             ins;    // open a slot at pos0, later entries move back
        logic             del;    // close the slot at pos0, later entries move forward
        logic             tap;    // the cell at pos0 drives its value into the read tree
        logic [POS_W-1:0] pos0;   // zero-based position
        logic [VAL_W-1:0] value;  // value to insert
    } t_cell_ctl;

    // Levels of the eight-way read-out tree for n leaves (n from 2 to 4096).
    function automatic int tree_levels(input int n);
        int lv;
        int span;
        lv   = 1;
        span = FANIN;
        while (span < n) begin
            lv   = lv + 1;
            span = span * FANIN;
        end
        return lv;
    endfunction

endpackage

// ===== rtl/core/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an entry, takes a neighbor's entry on insert or delete.
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int IDX = 0
) (
    input  logic                          i_clk,
    input  ple_pkg::t_cell_ctl            i_ctl,
    input  logic [ple_pkg::VAL_W-1:0]     i_left,
    input  logic [ple_pkg::VAL_W-1:0]     i_right,
    output logic [ple_pkg::VAL_W-1:0]     o_value,
    output logic [ple_pkg::VAL_W-1:0]     o_tap
);
    import ple_pkg::*;

    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] r_tap;
    logic             w_eq;
    logic             w_gt;

    assign w_eq = (IDX == int'(i_ctl.pos0));
    assign w_gt = (IDX >  int'(i_ctl.pos0));

    always_ff @(posedge i_clk) begin
        if (i_ctl.go) begin
            if (i_ctl.ins && w_eq) begin
                r_value <= i_ctl.value;
            end else if (i_ctl.ins && w_gt) begin
                r_value <= i_left;
            end else if (i_ctl.del && (w_eq || w_gt)) begin
                r_value <= i_right;
            end
            // The tap samples the entry before any move, so delete returns it.
            r_tap <= (i_ctl.tap && w_eq) ? r_value : '0;
        end
    end

    assign o_value = r_value;
    assign o_tap   = r_tap;

endmodule

// ===== rtl/core/ple_or_tree.sv =====
// ----------------------------------------------------------------------------
// ple_or_tree
// Registered eight-way OR tree that gathers the one nonzero cell tap.
// ----------------------------------------------------------------------------
module ple_or_tree #(
    parameter int N = 64
) (
    input  logic                      i_clk,
    input  logic [ple_pkg::VAL_W-1:0] i_leaf [N],
    output logic [ple_pkg::VAL_W-1:0] o_root
);
    import ple_pkg::*;

    localparam int L      = tree_levels(N);
    localparam int LEAVES = FANIN ** L;

    function automatic int level_off(input int lv);
        int off;
        off = 0;
        for (int j = 1; j < lv; j++) begin
            off = off + FANIN ** (L - j);
        end
        return off;
    endfunction

    localparam int NODES = level_off(L + 1);

    logic [VAL_W-1:0] w_leaf [LEAVES];
    logic [VAL_W-1:0] n_node [NODES];
    logic [VAL_W-1:0] r_node [NODES];

    for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
        if (g < N) begin : g_real
            assign w_leaf[g] = i_leaf[g];
        end else begin : g_pad
            assign w_leaf[g] = '0;
        end
    end

    for (genvar lv = 1; lv <= L; lv++) begin : g_lv
        localparam int CNT = FANIN ** (L - lv);
        localparam int OFF = level_off(lv);
        for (genvar j = 0; j < CNT; j++) begin : g_nd
            if (lv == 1) begin : g_first
                assign n_node[OFF + j] =
                    w_leaf[j*FANIN + 0] | w_leaf[j*FANIN + 1] |
                    w_leaf[j*FANIN + 2] | w_leaf[j*FANIN + 3] |
                    w_leaf[j*FANIN + 4] | w_leaf[j*FANIN + 5] |
                    w_leaf[j*FANIN + 6] | w_leaf[j*FANIN + 7];
            end else begin : g_upper
                localparam int COFF = level_off(lv - 1);
                assign n_node[OFF + j] =
                    r_node[COFF + j*FANIN + 0] | r_node[COFF + j*FANIN + 1] |
                    r_node[COFF + j*FANIN + 2] | r_node[COFF + j*FANIN + 3] |
                    r_node[COFF + j*FANIN + 4] | r_node[COFF + j*FANIN + 5] |
                    r_node[COFF + j*FANIN + 6] | r_node[COFF + j*FANIN + 7];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
    end

    assign o_root = r_node[NODES - 1];

endmodule

// ===== rtl/core/positional_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Ordered list of signed 32-bit entries with read, insert, delete and clear.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells; an insert or delete moves every
// later entry by one place in the cycle the item is accepted. The value read
// or deleted is gathered from the cells through a registered eight-way OR
// tree of L = ceil(log8(CAPACITY)) levels (2 for 64 entries). s_axis_tready
// stays low from acceptance until the result from the tree root is loaded
// into the output register; the load waits while an older result is unaccepted.
// A finished result waits in the output register while the next item is
// taken. Positions are 1-based; list_length reports the count after the operation.
module positional_list_engine_core #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // opcode[1:0], position[8:2], new_value[40:9]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // status[1:0], read_value[33:2], list_length[40:34]
);
    import ple_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int L     = tree_levels(CAPACITY);

    logic [OP_W-1:0]   w_op;
    logic [POS_W-1:0]  w_pos;
    logic [VAL_W-1:0]  w_new;
    logic              w_acc;
    logic [CMP_W-1:0]  w_pos_x;
    logic [CMP_W-1:0]  w_cnt_x;
    logic              w_rd_bad;
    logic              w_ins_bad;
    logic              w_full;
    logic [STAT_W-1:0] w_stat;
    t_cell_ctl         w_ctl;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_busy;
    logic [WAIT_W-1:0] r_wait;
    logic [STAT_W-1:0] r_stat;
    logic              r_ovalid;
    logic [STAT_W-1:0] r_ostat;
    logic [VAL_W-1:0]  r_ordval;
    logic [LEN_W-1:0]  r_olen;
    logic              w_done;
    logic [CMP_W-1:0]  w_len_x;

    logic [VAL_W-1:0]  w_val [CAPACITY];
    logic [VAL_W-1:0]  w_tap [CAPACITY];
    logic [VAL_W-1:0]  w_root;

    assign w_op  = s_axis_tdata[1:0];
    assign w_pos = s_axis_tdata[8:2];
    assign w_new = s_axis_tdata[40:9];

    assign s_axis_tready = !r_busy;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    assign w_pos_x   = CMP_W'(w_pos);
    assign w_cnt_x   = CMP_W'(r_count);
    assign w_full    = (w_cnt_x == CMP_W'(CAPACITY));
    assign w_rd_bad  = (w_pos == '0) || (w_pos_x > w_cnt_x);
    assign w_ins_bad = (w_pos == '0) || ({1'b0, w_pos_x} > ({1'b0, w_cnt_x} + 1'b1));

    always_comb begin
        w_stat      = ST_OK;
        n_count     = r_count;
        w_ctl.go    = w_acc;
        w_ctl.ins   = 1'b0;
        w_ctl.del   = 1'b0;
        w_ctl.tap   = 1'b0;
        w_ctl.pos0  = w_pos - 1'b1;
        w_ctl.value = w_new;
        case (w_op)
            OP_READ: begin
                if (w_rd_bad) begin
                    w_stat = ST_POS;
                end else begin
                    w_ctl.tap = 1'b1;
                end
            end
            OP_INSERT: begin
                if (w_full) begin
                    w_stat = ST_FULL;
                end else if (w_ins_bad) begin
                    w_stat = ST_POS;
                end else begin
                    w_ctl.ins = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            OP_DELETE: begin
                if (w_rd_bad) begin
                    w_stat = ST_POS;
                end else begin
                    w_ctl.del = 1'b1;
                    w_ctl.tap = 1'b1;
                    n_count   = r_count - 1'b1;
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VAL_W-1:0] w_l;
        logic [VAL_W-1:0] w_r;
        if (i == 0) begin : g_head
            assign w_l = w_new;
        end else begin : g_mid_l
            assign w_l = w_val[i - 1];
        end
        if (i == CAPACITY - 1) begin : g_tail
            assign w_r = '0;
        end else begin : g_mid_r
            assign w_r = w_val[i + 1];
        end
        ple_cell #(
            .IDX (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_left  (w_l),
            .i_right (w_r),
            .o_value (w_val[i]),
            .o_tap   (w_tap[i])
        );
    end

    ple_or_tree #(
        .N (CAPACITY)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_tap),
        .o_root (w_root)
    );

    assign w_done  = r_busy && (r_wait == WAIT_W'(L)) && (!r_ovalid || m_axis_tready);
    assign w_len_x = CMP_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_busy   <= 1'b0;
            r_wait   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count <= n_count;
                r_busy  <= 1'b1;
                r_wait  <= '0;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end else if (r_busy && (r_wait != WAIT_W'(L))) begin
                r_wait <= r_wait + 1'b1;
            end
            if (w_done) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_stat <= w_stat;
        end
        if (w_done) begin
            r_ostat  <= r_stat;
            r_ordval <= w_root;
            r_olen   <= w_len_x[LEN_W-1:0];
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_olen, r_ordval, r_ostat};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt_x <= CMP_W'(CAPACITY))
        else $error("list length exceeds capacity");

    a_full_insert_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_op == OP_INSERT) && w_full) |=> (r_count == $past(r_count)))
        else $error("insert into a full list changed the length");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_busy && (r_wait == '0)))
        else $error("accepted item did not start the read-out wait");

    a_done_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_busy))
        else $error("result appeared without an item in flight");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks positional_list_engine_core item by item against a software copy of
// the list.
// A queue of list operations is filled up front. It starts with a short
// directed run over empty, boundary and error cases. After that come random
// phases that either wander around a middling length or fill the list to
// capacity and hammer the full and last-position cases. A driver feeds the
// input stream and shadows every accepted item in its own copy of the list.
// A monitor compares each result with the oldest expected one. Both sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    localparam int LIST_DEPTH   = 64;
    localparam int RANDOM_ITEMS = 650;
    localparam int IDLE_PCT     = 17;
    localparam int CALM_FROM    = 1200;   // no idling on either side in this cycle window
    localparam int CALM_TO      = 2000;
    localparam int HOLD_AT      = 600;    // the receiver's long hold-off starts here
    localparam int HOLD_LEN     = 80;
    localparam int WATCHDOG     = 1000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
    } t_list_op;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  rd_value;
        logic [LEN_W-1:0]  length;
    } t_list_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;  // opcode[1:0], position[8:2], new_value[40:9]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // status[1:0], read_value[33:2], list_length[40:34]

    // Shadow copy of the list, updated at each accepted item.
    logic [VAL_W-1:0] list_mem [LIST_DEPTH];
    int               list_len = 0;

    t_list_op     pending_ops[$];
    t_list_result expected_results[$];

    int gen_len       = 0;  // list length as seen by the stimulus generator
    int cycle_no      = 0;
    int idle_cycles   = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int op_count [4]  = '{0, 0, 0, 0};
    int pos_errors    = 0;
    int full_errors   = 0;
    int peak_len      = 0;

    positional_list_engine_core #(
        .CAPACITY(LIST_DEPTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Applies one operation to the shadow list and returns what the block must answer.
    function automatic t_list_result apply_list_op(input logic [47:0] word);
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        t_list_result     res;
        int               k;
        op           = word[1:0];
        pos          = word[8:2];
        val          = word[40:9];
        res.status   = ST_OK;
        res.rd_value = '0;
        case (op)
            OP_READ: begin
                if (pos == 0 || pos > list_len) begin
                    res.status = ST_POS;
                end else begin
                    res.rd_value = list_mem[pos - 1];
                end
            end
            OP_INSERT: begin
                if (list_len >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else if (pos == 0 || pos > list_len + 1) begin
                    res.status = ST_POS;
                end else begin
                    for (k = list_len; k >= pos; k--) begin
                        list_mem[k] = list_mem[k - 1];
                    end
                    list_mem[pos - 1] = val;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (pos == 0 || pos > list_len) begin
                    res.status = ST_POS;
                end else begin
                    res.rd_value = list_mem[pos - 1];
                    for (k = pos; k < list_len; k++) begin
                        list_mem[k - 1] = list_mem[k];
                    end
                    list_len--;
                end
            end
            default: begin
                list_len = 0;
            end
        endcase
        res.length = list_len[LEN_W-1:0];
        op_count[op]++;
        if (res.status == ST_POS) pos_errors++;
        if (res.status == ST_FULL) full_errors++;
        if (list_len > peak_len) peak_len = list_len;
        return res;
    endfunction

    // Queues an operation and tracks the length the list will have after it.
    task automatic queue_op(input logic [OP_W-1:0] op, input int pos, input logic [VAL_W-1:0] val);
        t_list_op item;
        item.op  = op;
        item.pos = pos[POS_W-1:0];
        item.val = val;
        pending_ops.push_back(item);
        case (op)
            OP_INSERT: if (gen_len < LIST_DEPTH && pos >= 1 && pos <= gen_len + 1) gen_len++;
            OP_DELETE: if (pos >= 1 && pos <= gen_len) gen_len--;
            OP_CLEAR:  gen_len = 0;
            default: ;
        endcase
    endtask

    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly a valid position for the operation, now and then any position from 0 to LIST_DEPTH + 1.
    function automatic int pick_position(input logic [OP_W-1:0] op);
        int top;
        top = (op == OP_INSERT) ? gen_len + 1 : gen_len;
        if (top == 0 || $urandom_range(99) < 12) return $urandom_range(LIST_DEPTH + 1, 0);
        return $urandom_range(top, 1);
    endfunction

    task automatic build_stimulus();
        int               sent;
        int               steps;
        int               k;
        int               pick;
        logic [OP_W-1:0]  op;
        // Empty list: every position is an error, insert needs position one.
        queue_op(OP_READ, 0, '0);
        queue_op(OP_READ, 1, '0);
        queue_op(OP_DELETE, 1, '0);
        queue_op(OP_INSERT, 0, 32'h1234_5678);
        queue_op(OP_INSERT, 2, 32'h1234_5678);
        // Build a short list at the front, the middle and the end.
        queue_op(OP_INSERT, 1, 32'h7FFF_FFFF);
        queue_op(OP_INSERT, 1, 32'h8000_0000);
        queue_op(OP_INSERT, 3, 32'hFFFF_FFFF);
        queue_op(OP_INSERT, 2, 32'h0000_0000);
        for (k = 1; k <= 5; k++) queue_op(OP_READ, k, '0);
        queue_op(OP_READ, LIST_DEPTH + 1, '0);
        queue_op(OP_INSERT, LIST_DEPTH + 1, 32'h5555_5555);
        queue_op(OP_DELETE, 0, '0);
        queue_op(OP_DELETE, 2, '0);
        queue_op(OP_DELETE, 4, '0);
        queue_op(OP_DELETE, 3, '0);
        // Clear ignores its position and value.
        queue_op(OP_CLEAR, LIST_DEPTH + 1, 32'hAAAA_AAAA);
        queue_op(OP_READ, 1, '0);
        queue_op(OP_INSERT, 1, 32'hDEAD_BEEF);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent == 0 || $urandom_range(99) < 20) begin
                // Fill to capacity, then poke the full list and its last entry.
                while (gen_len < LIST_DEPTH) begin
                    queue_op(OP_INSERT, $urandom_range(gen_len + 1, 1), random_value());
                    sent++;
                end
                steps = $urandom_range(3, 2);
                for (k = 0; k < steps; k++) begin
                    pick = $urandom_range(3);
                    queue_op(OP_INSERT, (pick == 0) ? 0 : (pick == 1) ? 1 :
                             (pick == 2) ? LIST_DEPTH + 1 : $urandom_range(LIST_DEPTH, 2),
                             random_value());
                end
                queue_op(OP_READ, LIST_DEPTH, '0);
                queue_op(OP_READ, LIST_DEPTH + 1, '0);
                queue_op(OP_READ, $urandom_range(LIST_DEPTH, 1), '0);
                queue_op(OP_DELETE, LIST_DEPTH, '0);
                queue_op(OP_INSERT, LIST_DEPTH, random_value());
                queue_op(OP_DELETE, 1, '0);
                sent += steps + 6;
            end else begin
                steps = $urandom_range(40, 20);
                for (k = 0; k < steps; k++) begin
                    pick = $urandom_range(99);
                    op   = (pick < 35) ? OP_READ : (pick < 68) ? OP_INSERT :
                           (pick < 97) ? OP_DELETE : OP_CLEAR;
                    queue_op(op, pick_position(op), random_value());
                end
                sent += steps;
            end
        end
    endtask

    function automatic logic [47:0] pack_op(input t_list_op item);
        return {7'd0, item.val, item.pos, item.op};
    endfunction

    function automatic bit idling_allowed(input int cyc);
        return !(cyc >= CALM_FROM && cyc < CALM_TO);
    endfunction

    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
    end

    // Sender: keeps offering items from the queue, with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(apply_list_op(s_axis_tdata));
                items_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_ops.size() != 0 &&
                    !(idling_allowed(cycle_no) && $urandom_range(99) < IDLE_PCT)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pack_op(pending_ops.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random stalls plus one long hold-off that backs up the block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (cycle_no == HOLD_AT) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_LEN;
        end else begin
            m_axis_tready <= !(idling_allowed(cycle_no) && $urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic note_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] result %0d: %s expected %h, got %h", $realtime, results_seen, what,
                     want, got);
        end
    endtask

    // Monitor: every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                note_mismatch("unexpected item, data", '0, m_axis_tdata[31:0]);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata[1:0] !== want.status) begin
                    note_mismatch("status", 32'(want.status), 32'(m_axis_tdata[1:0]));
                end
                if (m_axis_tdata[33:2] !== want.rd_value) begin
                    note_mismatch("read_value", want.rd_value, m_axis_tdata[33:2]);
                end
                if (m_axis_tdata[40:34] !== want.length) begin
                    note_mismatch("list_length", 32'(want.length), 32'(m_axis_tdata[40:34]));
                end
            end
            results_seen++;
        end
    end

    // Watchdog: ends the run if neither side moves an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG) begin
            $display("timeout after %0d cycles without an item, %0d results still due",
                     WATCHDOG, expected_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        build_stimulus();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_ops.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d items: %0d reads, %0d inserts, %0d deletes, %0d clears", items_sent,
                 op_count[OP_READ], op_count[OP_INSERT], op_count[OP_DELETE], op_count[OP_CLEAR]);
        $display("%0d position errors, %0d full-list errors, peak length %0d, %0d mismatches",
                 pos_errors, full_errors, peak_len, mismatches);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ple_pkg.sv
rtl/core/ple_cell.sv
rtl/core/ple_or_tree.sv
rtl/core/positional_list_engine_core.sv
tb/testbench.sv
